@@ rtl/keyed_record_space_manager_top_macros.svh @@
// ----------------------------------------------------------------------------
// Keyed record space manager assertion macros
// Concurrent assertion helpers shared by the RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_SPACE_MANAGER_TOP_MACROS_SVH
`define KEYED_RECORD_SPACE_MANAGER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define KRSM_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: condition must never hold");
`define KRSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");
`else
`define KRSM_ASSERT_NEVER(label, clk, rst, cond)
`define KRSM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/krsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyed record space manager package
// Request, status and policy codes, sequencer states and compare unit types.
// ----------------------------------------------------------------------------
package krsm_pkg;

   localparam logic [1:0] REQ_ADD  = 2'd0;
   localparam logic [1:0] REQ_FIND = 2'd1;
   localparam logic [1:0] REQ_DEL  = 2'd2;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EXISTS   = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // Every stored record carries a four byte header ahead of its payload.
   localparam logic [11:0] HDR_BYTES = 12'd4;

   typedef enum logic [4:0] {
      S_IDLE, S_FIND_RD, S_FIND_CMP, S_DISPATCH, S_HS_RD, S_HS_CMP,
      S_HD_RD, S_HD_WR, S_PUSH, S_SO_OUT, S_SO_KEY, S_SO_RD, S_SO_CMP,
      S_IS_RD, S_IS_WR, S_ID_RD, S_ID_WR, S_RESP
   } seq_state_type;

   typedef enum logic [1:0] {
      CMP_KEY, CMP_FIT, CMP_ORDER
   } cmp_op_type;

   typedef struct packed {
      logic eq;
      logic hit;
   } cmp_res_type;

endpackage

@@ rtl/krsm_if.sv @@
// ----------------------------------------------------------------------------
// Keyed record space manager channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
interface krsm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [31:0] record_key;
   logic [10:0]        record_length;

   modport source (output valid, req_type, record_key, record_length, input ready);
   modport sink (input valid, req_type, record_key, record_length, output ready);
endinterface

interface krsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] record_offset;
   logic [10:0] found_length;

   modport source (output valid, status, record_offset, found_length, input ready);
   modport sink (input valid, status, record_offset, found_length, output ready);
endinterface

@@ rtl/krsm_cmp.sv @@
// ----------------------------------------------------------------------------
// Keyed record space manager compare unit
// Shared comparator for key search, hole fit and hole ordering.
// ----------------------------------------------------------------------------
module krsm_cmp #(
   parameter int OFFSET_BITS = 32
) (
   input  krsm_pkg::cmp_op_type  op,
   input  logic [1:0]            policy,
   input  logic signed [31:0]    a_key,
   input  logic signed [31:0]    b_key,
   input  logic [11:0]           a_size,
   input  logic [11:0]           b_size,
   input  logic [OFFSET_BITS-1:0] a_off,
   input  logic [OFFSET_BITS-1:0] b_off,
   output krsm_pkg::cmp_res_type res
);
   import krsm_pkg::*;

   always_comb begin
      res = '0;
      case (op)
         CMP_KEY: begin
            res.eq  = (a_key == b_key);
            res.hit = (a_key > b_key);
         end
         CMP_FIT: begin
            res.hit = (a_size >= b_size);
         end
         CMP_ORDER: begin
            // Hole a goes before hole b; equal sizes order by offset.
            if (a_size == b_size) begin
               res.hit = (a_off < b_off);
            end else if (policy == FIT_BEST) begin
               res.hit = (a_size < b_size);
            end else begin
               res.hit = (a_size > b_size);
            end
         end
         default: begin
            res = '0;
         end
      endcase
   end
endmodule

@@ rtl/keyed_record_space_manager_top.sv @@
// ----------------------------------------------------------------------------
// Keyed record space manager
// Key-sorted record index with a first/best/worst-fit free hole allocator.
// ----------------------------------------------------------------------------
// One request is taken at a time and its response is held until transferred.
// The sequencer walks the record index and the hole list in block RAMs with a
// single read and write port each; every step issues a read and then compares
// the word in the shared compare unit or moves it. A find scans the index from
// the start until it meets an equal or larger key. An add scans the holes for a
// fit, shifts the later holes down over the taken one, shifts index entries up
// and, under best or worst fit, runs an insertion sort pass over the holes when
// a remainder is pushed back; after a policy change the first sort is quadratic
// in the hole count. A delete runs the find, the hole insertion with its sort
// and shifts index entries down. No clearing pass is run after reset: entries
// are only read below their counts.
`include "keyed_record_space_manager_top_macros.svh"

module keyed_record_space_manager_top #(
   parameter int INDEX_ENTRIES = 1024,
   parameter int HOLE_ENTRIES  = 1024,
   parameter int OFFSET_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   krsm_req_if.sink    req_chan,
   krsm_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata
);
   import krsm_pkg::*;

   localparam int IA  = $clog2(INDEX_ENTRIES);
   localparam int HA  = $clog2(HOLE_ENTRIES);
   localparam int ICW = $clog2(INDEX_ENTRIES + 1);
   localparam int HCW = $clog2(HOLE_ENTRIES + 1);
   localparam int OB  = OFFSET_BITS;

   typedef struct packed {
      logic signed [31:0] key;
      logic [OB-1:0]      off;
      logic [10:0]        len;
   } idx_entry_type;

   typedef struct packed {
      logic [11:0]   size;
      logic [OB-1:0] off;
   } hole_entry_type;

   // Record index and hole list storage, one read and one write port each.
   idx_entry_type  idx_mem  [INDEX_ENTRIES];
   hole_entry_type hole_mem [HOLE_ENTRIES];

   logic           idx_we, hole_we;
   logic [IA-1:0]  idx_wa, idx_ra;
   logic [HA-1:0]  hole_wa, hole_ra;
   idx_entry_type  idx_wd, idx_rdata_ff;
   hole_entry_type hole_wd, hole_rdata_ff;

   always_ff @(posedge clock) begin
      if (idx_we) begin
         idx_mem[idx_wa] <= idx_wd;
      end
      idx_rdata_ff <= idx_mem[idx_ra];
   end

   always_ff @(posedge clock) begin
      if (hole_we) begin
         hole_mem[hole_wa] <= hole_wd;
      end
      hole_rdata_ff <= hole_mem[hole_ra];
   end

   // Sequencer state and working registers.
   seq_state_type      state_ff, state_in;
   logic [1:0]         pol_ff;
   logic [1:0]         req_type_ff, req_type_in;
   logic signed [31:0] key_ff, key_in;
   logic [10:0]        len_ff, len_in;
   logic [11:0]        need_ff, need_in;
   logic [1:0]         status_ff, status_in;
   logic [OB-1:0]      off_ff, off_in;
   logic [10:0]        flen_ff, flen_in;
   logic [ICW-1:0]     icnt_ff, icnt_in;
   logic [HCW-1:0]     hcnt_ff, hcnt_in;
   logic [OB-1:0]      fend_ff, fend_in;
   logic [ICW-1:0]     ic_ff, ic_in;
   logic [ICW-1:0]     pos_ff, pos_in;
   logic               found_ff, found_in;
   logic [OB-1:0]      ent_off_ff, ent_off_in;
   logic [10:0]        ent_len_ff, ent_len_in;
   logic [HCW-1:0]     hc_ff, hc_in;
   logic [HCW-1:0]     sj_ff, sj_in;
   hole_entry_type     sk_ff, sk_in;
   logic [11:0]        push_size_ff, push_size_in;
   logic [OB-1:0]      push_off_ff, push_off_in;

   // Shared compare unit.
   cmp_op_type  cmp_op;
   cmp_res_type cmp_res;
   logic signed [31:0] cmp_a_key;
   logic [11:0]        cmp_a_size, cmp_b_size;
   logic [OB-1:0]      cmp_a_off, cmp_b_off;

   krsm_cmp #(
      .OFFSET_BITS(OB)
   ) u_cmp (
      .op     (cmp_op),
      .policy (pol_ff),
      .a_key  (cmp_a_key),
      .b_key  (key_ff),
      .a_size (cmp_a_size),
      .b_size (cmp_b_size),
      .a_off  (cmp_a_off),
      .b_off  (cmp_b_off),
      .res    (cmp_res)
   );

   // Append check: a carry out of the offset range means the space is full.
   logic [OB:0]    fend_sum;
   logic [ICW-1:0] ic_dec, ic_inc;
   logic [HCW-1:0] hc_inc, sj_dec;
   logic           sorting;

   assign fend_sum = {1'b0, fend_ff} + (OB + 1)'(need_ff);
   assign ic_dec   = ic_ff - 1'b1;
   assign ic_inc   = ic_ff + 1'b1;
   assign hc_inc   = hc_ff + 1'b1;
   assign sj_dec   = sj_ff - 1'b1;
   assign sorting  = (pol_ff == FIT_BEST) || (pol_ff == FIT_WORST);

   always_ff @(posedge clock) begin
      if (reset) begin
         pol_ff <= FIT_FIRST;
      end else if (csr_we) begin
         pol_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         icnt_ff  <= '0;
         hcnt_ff  <= '0;
         fend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         icnt_ff  <= icnt_in;
         hcnt_ff  <= hcnt_in;
         fend_ff  <= fend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff  <= req_type_in;
      key_ff       <= key_in;
      len_ff       <= len_in;
      need_ff      <= need_in;
      status_ff    <= status_in;
      off_ff       <= off_in;
      flen_ff      <= flen_in;
      ic_ff        <= ic_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      ent_off_ff   <= ent_off_in;
      ent_len_ff   <= ent_len_in;
      hc_ff        <= hc_in;
      sj_ff        <= sj_in;
      sk_ff        <= sk_in;
      push_size_ff <= push_size_in;
      push_off_ff  <= push_off_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_type_in  = req_type_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      need_in      = need_ff;
      status_in    = status_ff;
      off_in       = off_ff;
      flen_in      = flen_ff;
      icnt_in      = icnt_ff;
      hcnt_in      = hcnt_ff;
      fend_in      = fend_ff;
      ic_in        = ic_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      ent_off_in   = ent_off_ff;
      ent_len_in   = ent_len_ff;
      hc_in        = hc_ff;
      sj_in        = sj_ff;
      sk_in        = sk_ff;
      push_size_in = push_size_ff;
      push_off_in  = push_off_ff;

      idx_we  = 1'b0;
      idx_wa  = '0;
      idx_wd  = '0;
      idx_ra  = '0;
      hole_we = 1'b0;
      hole_wa = '0;
      hole_wd = '0;
      hole_ra = '0;

      cmp_op     = CMP_KEY;
      cmp_a_key  = idx_rdata_ff.key;
      cmp_a_size = hole_rdata_ff.size;
      cmp_b_size = need_ff;
      cmp_a_off  = hole_rdata_ff.off;
      cmp_b_off  = hole_rdata_ff.off;

      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               req_type_in = req_chan.req_type;
               key_in      = req_chan.record_key;
               len_in      = req_chan.record_length;
               need_in     = HDR_BYTES + {1'b0, req_chan.record_length};
               status_in   = ST_OK;
               off_in      = '0;
               flen_in     = '0;
               ic_in       = '0;
               found_in    = 1'b0;
               state_in    = S_FIND_RD;
            end
         end
         S_FIND_RD: begin
            if (ic_ff == icnt_ff) begin
               pos_in   = ic_ff;
               state_in = S_DISPATCH;
            end else begin
               idx_ra   = ic_ff[IA-1:0];
               state_in = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            cmp_op = CMP_KEY;
            if (cmp_res.eq) begin
               found_in   = 1'b1;
               pos_in     = ic_ff;
               ent_off_in = idx_rdata_ff.off;
               ent_len_in = idx_rdata_ff.len;
               state_in   = S_DISPATCH;
            end else if (cmp_res.hit) begin
               pos_in   = ic_ff;
               state_in = S_DISPATCH;
            end else begin
               ic_in    = ic_inc;
               state_in = S_FIND_RD;
            end
         end
         S_DISPATCH: begin
            state_in = S_RESP;
            case (req_type_ff)
               REQ_ADD: begin
                  if (found_ff) begin
                     status_in = ST_EXISTS;
                  end else if (icnt_ff >= ICW'(INDEX_ENTRIES)) begin
                     status_in = ST_FULL;
                  end else begin
                     hc_in    = '0;
                     state_in = S_HS_RD;
                  end
               end
               REQ_FIND: begin
                  if (found_ff) begin
                     off_in  = ent_off_ff;
                     flen_in = ent_len_ff;
                  end else begin
                     status_in = ST_NOTFOUND;
                  end
               end
               REQ_DEL: begin
                  if (!found_ff) begin
                     status_in = ST_NOTFOUND;
                  end else if (hcnt_ff >= HCW'(HOLE_ENTRIES)) begin
                     status_in = ST_FULL;
                  end else begin
                     off_in       = ent_off_ff;
                     push_size_in = HDR_BYTES + {1'b0, ent_len_ff};
                     push_off_in  = ent_off_ff;
                     state_in     = S_PUSH;
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         S_HS_RD: begin
            if (hc_ff == hcnt_ff) begin
               // No hole fits: append at the file end if the range allows.
               if (fend_sum[OB]) begin
                  status_in = ST_FULL;
                  state_in  = S_RESP;
               end else begin
                  off_in   = fend_ff;
                  fend_in  = fend_sum[OB-1:0];
                  ic_in    = icnt_ff;
                  state_in = S_IS_RD;
               end
            end else begin
               hole_ra  = hc_ff[HA-1:0];
               state_in = S_HS_CMP;
            end
         end
         S_HS_CMP: begin
            cmp_op = CMP_FIT;
            if (cmp_res.hit) begin
               off_in       = hole_rdata_ff.off;
               push_size_in = hole_rdata_ff.size - need_ff;
               push_off_in  = hole_rdata_ff.off + OB'(need_ff);
               state_in     = S_HD_RD;
            end else begin
               hc_in    = hc_inc;
               state_in = S_HS_RD;
            end
         end
         S_HD_RD: begin
            if (hc_inc >= hcnt_ff) begin
               hcnt_in = hcnt_ff - 1'b1;
               if (push_size_ff != '0) begin
                  state_in = S_PUSH;
               end else begin
                  ic_in    = icnt_ff;
                  state_in = S_IS_RD;
               end
            end else begin
               hole_ra  = hc_inc[HA-1:0];
               state_in = S_HD_WR;
            end
         end
         S_HD_WR: begin
            hole_we  = 1'b1;
            hole_wa  = hc_ff[HA-1:0];
            hole_wd  = hole_rdata_ff;
            hc_in    = hc_inc;
            state_in = S_HD_RD;
         end
         S_PUSH: begin
            hole_we = 1'b1;
            hole_wa = hcnt_ff[HA-1:0];
            hole_wd = '{size: push_size_ff, off: push_off_ff};
            hcnt_in = hcnt_ff + 1'b1;
            if (sorting) begin
               hc_in    = HCW'(1);
               state_in = S_SO_OUT;
            end else if (req_type_ff == REQ_ADD) begin
               ic_in    = icnt_ff;
               state_in = S_IS_RD;
            end else begin
               ic_in    = pos_ff;
               state_in = S_ID_RD;
            end
         end
         S_SO_OUT: begin
            if (hc_ff >= hcnt_ff) begin
               if (req_type_ff == REQ_ADD) begin
                  ic_in    = icnt_ff;
                  state_in = S_IS_RD;
               end else begin
                  ic_in    = pos_ff;
                  state_in = S_ID_RD;
               end
            end else begin
               hole_ra  = hc_ff[HA-1:0];
               state_in = S_SO_KEY;
            end
         end
         S_SO_KEY: begin
            sk_in    = hole_rdata_ff;
            sj_in    = hc_ff;
            state_in = S_SO_RD;
         end
         S_SO_RD: begin
            if (sj_ff == '0) begin
               hole_we  = 1'b1;
               hole_wa  = '0;
               hole_wd  = sk_ff;
               hc_in    = hc_inc;
               state_in = S_SO_OUT;
            end else begin
               hole_ra  = sj_dec[HA-1:0];
               state_in = S_SO_CMP;
            end
         end
         S_SO_CMP: begin
            cmp_op     = CMP_ORDER;
            cmp_a_size = sk_ff.size;
            cmp_b_size = hole_rdata_ff.size;
            cmp_a_off  = sk_ff.off;
            cmp_b_off  = hole_rdata_ff.off;
            hole_we    = 1'b1;
            hole_wa    = sj_ff[HA-1:0];
            if (cmp_res.hit) begin
               hole_wd  = hole_rdata_ff;
               sj_in    = sj_dec;
               state_in = S_SO_RD;
            end else begin
               hole_wd  = sk_ff;
               hc_in    = hc_inc;
               state_in = S_SO_OUT;
            end
         end
         S_IS_RD: begin
            if (ic_ff == pos_ff) begin
               idx_we    = 1'b1;
               idx_wa    = pos_ff[IA-1:0];
               idx_wd    = '{key: key_ff, off: off_in, len: len_ff};
               icnt_in   = icnt_ff + 1'b1;
               status_in = ST_OK;
               state_in  = S_RESP;
            end else begin
               idx_ra   = ic_dec[IA-1:0];
               state_in = S_IS_WR;
            end
         end
         S_IS_WR: begin
            idx_we   = 1'b1;
            idx_wa   = ic_ff[IA-1:0];
            idx_wd   = idx_rdata_ff;
            ic_in    = ic_dec;
            state_in = S_IS_RD;
         end
         S_ID_RD: begin
            if (ic_inc >= icnt_ff) begin
               icnt_in  = icnt_ff - 1'b1;
               state_in = S_RESP;
            end else begin
               idx_ra   = ic_inc[IA-1:0];
               state_in = S_ID_WR;
            end
         end
         S_ID_WR: begin
            idx_we   = 1'b1;
            idx_wa   = ic_ff[IA-1:0];
            idx_wd   = idx_rdata_ff;
            ic_in    = ic_inc;
            state_in = S_ID_RD;
         end
         S_RESP: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The reported offset is the low 32 bits of the internal offset.
   logic [OB+31:0] off_wide;
   assign off_wide = {32'b0, off_ff};

   assign rsp_chan.status        = status_ff;
   assign rsp_chan.record_offset = off_wide[31:0];
   assign rsp_chan.found_length  = flen_ff;

   `KRSM_ASSERT_NEVER(a_icnt_range, clock, reset, icnt_ff > ICW'(INDEX_ENTRIES))
   `KRSM_ASSERT_NEVER(a_hcnt_range, clock, reset, hcnt_ff > HCW'(HOLE_ENTRIES))
   `KRSM_ASSERT_IMPLY(a_push_room, clock, reset, state_ff == S_PUSH, hcnt_ff < HCW'(HOLE_ENTRIES))
   `KRSM_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_chan.valid && status_ff != ST_OK, off_ff == '0 && flen_ff == '0)
   `KRSM_ASSERT_IMPLY(a_one_busy, clock, reset, req_chan.ready, !rsp_chan.valid)

endmodule
